// ----- design/assert_macros.svh -----
// Assertion macros shared by the receiver RTL.
// Depends on: a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ----- design/i2ctr_pkg.sv -----
// Package for the length-prefixed I2C target receiver: sizes, codes and shared types.
// Depends on nothing; used by every module of the block.
package i2ctr_pkg;

    localparam int MAX_LEN     = 32;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int OWN_ADDR_W  = 7;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [OWN_ADDR_W-1:0] OWN_ADDR_RESET = 7'd8;
    localparam logic [LEN_W-1:0]      CNT_MAX        = 6'd63;
    localparam logic                  REG_OWN_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_BYTE     = 2'd1,
        OP_ACK_DONE = 2'd2,
        OP_TIMEOUT  = 2'd3
    } op_t;

    typedef enum logic {
        JOB_STATUS = 1'b0,
        JOB_DONE   = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic             sda;
        logic             rd;
        logic [LEN_W-1:0] len;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

endpackage

// ----- design/i2ctr_fifo.sv -----
// Two-entry queue of result jobs between the event front end and the result back end.
// Depends on i2ctr_pkg.
module i2ctr_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2ctr_pkg::job_t   job_in,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output i2ctr_pkg::job_t   job_out
);

    i2ctr_pkg::job_t                    entry_reg [i2ctr_pkg::QUEUE_DEPTH];
    logic [i2ctr_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [i2ctr_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [i2ctr_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full    = (count_reg == i2ctr_pkg::QCNT_W'(i2ctr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ----- design/i2ctr_front.sv -----
// Front end: accepts bus events, runs the byte-level phase machine and fills the payload store.
// Depends on i2ctr_pkg; feeds i2ctr_fifo and the store port of i2ctr_back.
module i2ctr_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            opcode,
    input  logic [i2ctr_pkg::BYTE_W-1:0]          data_byte,
    input  logic [i2ctr_pkg::OWN_ADDR_W-1:0]      own_address,
    input  logic                                  q_full,
    output logic                                  q_push,
    output i2ctr_pkg::job_t                       q_job,
    output i2ctr_pkg::store_wr_t                  store_wr,
    input  logic                                  run_end
);

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_ADDR       = 6'b000010,
        PH_W_ADDR_ACK = 6'b000100,
        PH_W_BYTE     = 6'b001000,
        PH_W_BYTE_ACK = 6'b010000,
        PH_R_ADDR_ACK = 6'b100000
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [i2ctr_pkg::LEN_W-1:0]       decl_len_reg, decl_len_next;
    logic [i2ctr_pkg::LEN_W-1:0]       byte_cnt_reg, byte_cnt_next;
    logic                              pend_reg, pend_next;
    logic                              accept;
    logic                              rd;
    logic                              complete;
    i2ctr_pkg::op_t                    op;

    assign op       = i2ctr_pkg::op_t'(opcode);
    assign in_ready = !q_full && !pend_reg;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    always_comb
    begin
        phase_next    = phase_reg;
        decl_len_next = decl_len_reg;
        byte_cnt_next = byte_cnt_reg;
        rd            = 1'b0;
        complete      = 1'b0;
        store_wr      = '0;

        unique case (op)
            i2ctr_pkg::OP_START:
            begin
                phase_next = PH_ADDR;
            end
            i2ctr_pkg::OP_TIMEOUT:
            begin
                phase_next = PH_IDLE;
            end
            i2ctr_pkg::OP_BYTE:
            begin
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        if (data_byte[i2ctr_pkg::BYTE_W-1:1] == own_address)
                        begin
                            byte_cnt_next = '0;
                            if (data_byte[0])
                            begin
                                phase_next = PH_R_ADDR_ACK;
                                rd         = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_W_ADDR_ACK;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_W_BYTE:
                    begin
                        if (byte_cnt_reg == '0)
                        begin
                            if (data_byte > i2ctr_pkg::BYTE_W'(i2ctr_pkg::MAX_LEN))
                            begin
                                decl_len_next = i2ctr_pkg::LEN_W'(i2ctr_pkg::MAX_LEN);
                            end
                            else
                            begin
                                decl_len_next = data_byte[i2ctr_pkg::LEN_W-1:0];
                            end
                        end
                        else if (byte_cnt_reg <= i2ctr_pkg::LEN_W'(i2ctr_pkg::MAX_LEN))
                        begin
                            store_wr.en   = accept;
                            store_wr.addr = i2ctr_pkg::ADDR_W'(byte_cnt_reg - 1'b1);
                            store_wr.data = data_byte;
                        end
                        if (byte_cnt_reg != i2ctr_pkg::CNT_MAX)
                        begin
                            byte_cnt_next = byte_cnt_reg + 1'b1;
                        end
                        phase_next = PH_W_BYTE_ACK;
                    end
                    PH_IDLE, PH_W_ADDR_ACK, PH_W_BYTE_ACK, PH_R_ADDR_ACK:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            i2ctr_pkg::OP_ACK_DONE:
            begin
                unique case (phase_reg)
                    PH_W_ADDR_ACK:
                    begin
                        phase_next = PH_W_BYTE;
                    end
                    PH_R_ADDR_ACK:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_W_BYTE_ACK:
                    begin
                        if (byte_cnt_reg == '0 || byte_cnt_reg <= decl_len_reg)
                        begin
                            phase_next = PH_W_BYTE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            complete   = 1'b1;
                        end
                    end
                    PH_IDLE, PH_ADDR, PH_W_BYTE:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_job.kind = complete ? i2ctr_pkg::JOB_DONE : i2ctr_pkg::JOB_STATUS;
        q_job.sda  = (phase_next == PH_W_ADDR_ACK) || (phase_next == PH_W_BYTE_ACK) ||
                     (phase_next == PH_R_ADDR_ACK);
        q_job.rd   = rd;
        q_job.len  = decl_len_reg;

        pend_next = pend_reg;
        if (accept && complete && (decl_len_reg != '0))
        begin
            pend_next = 1'b1;
        end
        else if (run_end)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            decl_len_reg <= '0;
            byte_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                decl_len_reg <= decl_len_next;
                byte_cnt_reg <= byte_cnt_next;
            end
        end
    end

endmodule

// ----- design/i2ctr_back.sv -----
// Back end: holds the payload store, plays queued jobs out and drives the result register.
// Depends on i2ctr_pkg and assert_macros.svh; fed by i2ctr_fifo and i2ctr_front.
`include "assert_macros.svh"

module i2ctr_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  i2ctr_pkg::job_t                  q_job,
    output logic                             q_pop,
    input  i2ctr_pkg::store_wr_t             store_wr,
    output logic                             run_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             sda_hold_low,
    output logic                             read_requested,
    output logic                             payload_valid,
    output logic [i2ctr_pkg::BYTE_W-1:0]     payload_byte,
    output logic                             message_done,
    output logic [i2ctr_pkg::LEN_W-1:0]      message_length
);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_EMIT = 3'b100
    } bk_state_t;

    logic [i2ctr_pkg::BYTE_W-1:0]  store_mem [i2ctr_pkg::MAX_LEN];

    bk_state_t                     state_reg, state_next;
    logic [i2ctr_pkg::LEN_W-1:0]   idx_reg, idx_next;
    logic [i2ctr_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [i2ctr_pkg::BYTE_W-1:0]  rdata_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_sda_reg, out_rd_reg, out_pv_reg, out_done_reg;
    logic [i2ctr_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [i2ctr_pkg::LEN_W-1:0]   out_len_reg;

    logic                          free;
    logic                          last;
    logic                          load;
    logic                          ld_sda, ld_rd, ld_pv, ld_done;
    logic [i2ctr_pkg::BYTE_W-1:0]  ld_byte;
    logic [i2ctr_pkg::LEN_W-1:0]   ld_len;

    assign free = !out_valid_reg || out_ready;
    assign last = ((idx_reg + 1'b1) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        q_pop      = 1'b0;
        run_end    = 1'b0;
        load       = 1'b0;
        ld_sda     = 1'b0;
        ld_rd      = 1'b0;
        ld_pv      = 1'b0;
        ld_done    = 1'b0;
        ld_byte    = '0;
        ld_len     = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && free)
                begin
                    q_pop = 1'b1;
                    if (q_job.kind == i2ctr_pkg::JOB_STATUS)
                    begin
                        load   = 1'b1;
                        ld_sda = q_job.sda;
                        ld_rd  = q_job.rd;
                    end
                    else if (q_job.len == '0)
                    begin
                        load    = 1'b1;
                        ld_done = 1'b1;
                    end
                    else
                    begin
                        len_next   = q_job.len;
                        idx_next   = '0;
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (free)
                begin
                    load    = 1'b1;
                    ld_pv   = 1'b1;
                    ld_byte = rdata_reg;
                    ld_done = last;
                    ld_len  = len_reg;
                    if (last)
                    begin
                        run_end    = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        if (load)
        begin
            out_sda_reg  <= ld_sda;
            out_rd_reg   <= ld_rd;
            out_pv_reg   <= ld_pv;
            out_byte_reg <= ld_byte;
            out_done_reg <= ld_done;
            out_len_reg  <= ld_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_READ)
        begin
            rdata_reg <= store_mem[idx_reg[i2ctr_pkg::ADDR_W-1:0]];
        end
    end

    assign out_valid      = out_valid_reg;
    assign sda_hold_low   = out_sda_reg;
    assign read_requested = out_rd_reg;
    assign payload_valid  = out_pv_reg;
    assign payload_byte   = out_byte_reg;
    assign message_done   = out_done_reg;
    assign message_length = out_len_reg;

    `ASSERT_ALWAYS(a_payload_has_len,
        !(out_valid_reg && out_pv_reg) || ((out_len_reg != '0) && !out_sda_reg),
        "payload result without length or with SDA held")
    `ASSERT_ALWAYS(a_emit_in_range,
        (state_reg != BK_EMIT) || (idx_reg < len_reg),
        "payload index past message length")
    `ASSERT_NEXT(a_run_end_idle, run_end,
        (state_reg == BK_IDLE) && out_valid_reg && out_done_reg,
        "message run did not finish with a done result")

endmodule

// ----- design/i2c_target_length_prefixed_receiver_unit.sv -----
// Top level of the receive-only I2C target with length-prefixed messages.
// Depends on i2ctr_pkg, i2ctr_fifo, i2ctr_front and i2ctr_back.
//
// Input channel (in_valid/in_ready): one bus event per transaction, opcode
// plus the shifted-in data_byte. Output channel (out_valid/out_ready): one
// result per transaction. Each event but a message's completing one gives a
// status result: queued on acceptance, then loaded when the output is free;
// back-to-back events are taken one per cycle while the two-entry job queue
// and the output register drain. A completed message of n bytes gives n
// results, each a store read then a result load, the last marked message_done;
// a zero length gives one done result. While such a run plays out, in_ready
// stays low, since the payload store is shared with the next message.
// Output stall: the result register holds, the job queue fills, then in_ready
// drops; nothing is lost. Reset clears phase, counters, queue and output valid;
// own_address returns to 8. The store needs no clearing pass.
// APB register 0 (byte address 0): own_address in bits 6:0.
module i2c_target_length_prefixed_receiver_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [i2ctr_pkg::PADDR_W-1:0]         paddr,
    input  logic [i2ctr_pkg::PDATA_W-1:0]         pwdata,
    output logic [i2ctr_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            opcode,
    input  logic [i2ctr_pkg::BYTE_W-1:0]          data_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  sda_hold_low,
    output logic                                  read_requested,
    output logic                                  payload_valid,
    output logic [i2ctr_pkg::BYTE_W-1:0]          payload_byte,
    output logic                                  message_done,
    output logic [i2ctr_pkg::LEN_W-1:0]           message_length
);

    logic [i2ctr_pkg::OWN_ADDR_W-1:0]  own_addr_reg;
    logic                              reg_sel;
    logic                              q_full;
    logic                              q_empty;
    logic                              q_push;
    logic                              q_pop;
    logic                              run_end;
    i2ctr_pkg::job_t                   push_job;
    i2ctr_pkg::job_t                   head_job;
    i2ctr_pkg::store_wr_t              store_wr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == i2ctr_pkg::REG_OWN_ADDRESS);
    assign prdata  = reg_sel ? i2ctr_pkg::PDATA_W'(own_addr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= i2ctr_pkg::OWN_ADDR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            own_addr_reg <= pwdata[i2ctr_pkg::OWN_ADDR_W-1:0];
        end
    end

    i2ctr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .own_address (own_addr_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job),
        .store_wr    (store_wr),
        .run_end     (run_end)
    );

    i2ctr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (push_job),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .job_out (head_job)
    );

    i2ctr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_job          (head_job),
        .q_pop          (q_pop),
        .store_wr       (store_wr),
        .run_end        (run_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sda_hold_low   (sda_hold_low),
        .read_requested (read_requested),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .message_done   (message_done),
        .message_length (message_length)
    );

endmodule
